FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clocked on the signal named clock, reset named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/fscd_pkg.sv
// shared constants, types and a helper function for the framed serial command decoder
// no dependencies
package fscd_pkg;

   // frame characters and command codes
   localparam logic [7:0] BYTE_OPEN  = 8'h24;  // '$'
   localparam logic [7:0] BYTE_CLOSE = 8'h23;  // '#'
   localparam logic [7:0] CMD_FREQ   = 8'h30;  // '0'
   localparam logic [7:0] CMD_THRESH = 8'h31;  // '1'

   // write position saturates here
   localparam int INDEX_LIMIT = 128;
   localparam int INDEX_W     = $clog2(INDEX_LIMIT + 1);

   // only the first five positions are ever decoded
   localparam int STORE_DEPTH = 5;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int BYTE_W   = 8;
   localparam int FREQ_W   = 7;
   localparam int THRESH_W = 14;
   localparam int CSR_W    = 14;
   localparam int VALUE_W  = 19;
   localparam int DIGIT_W  = 9;

   localparam logic [FREQ_W-1:0]   FREQ_MIN_RESET   = FREQ_W'(20);
   localparam logic [FREQ_W-1:0]   FREQ_MAX_RESET   = FREQ_W'(40);
   localparam logic [THRESH_W-1:0] THRESH_MAX_RESET = THRESH_W'(1000);

   localparam logic signed [VALUE_W-1:0] K10   = VALUE_W'(10);
   localparam logic signed [VALUE_W-1:0] K100  = VALUE_W'(100);
   localparam logic signed [VALUE_W-1:0] K1000 = VALUE_W'(1000);

   typedef enum logic [1:0] {
      CSR_FREQ_MIN   = 2'd0,
      CSR_FREQ_MAX   = 2'd1,
      CSR_THRESH_MAX = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   // signed (byte - 48), widened to the result width
   function automatic logic signed [VALUE_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
      logic signed [DIGIT_W-1:0] d;
      d = $signed({1'b0, b}) - $signed(DIGIT_W'(48));
      return VALUE_W'(d);
   endfunction

endpackage

FILE: hdl/framed_serial_command_decoder.sv
// top level of the framed serial command decoder
// depends on fscd_pkg
//
// usage:
//   req channel carries one received serial byte per request (req_rx_byte).
//   '$' restarts the write position and opens a message, '#' closes an open
//   message and decodes it, every other byte goes to the write position,
//   which saturates at the index limit; only the first five positions are kept.
//   rsp channel carries one decoded command per closing '#' whose command byte
//   is '0' (frequency, two digits) or '1' (threshold, four digits), with a
//   range flag checked against the csr limits.
//   result: registered, shown in the cycle after the closing request is taken.
//   throughput: one request per cycle while req_stall is low; the whole decode
//   sits between the request handshake and the result register.
//   stall: a held result blocks new requests only while rsp_stall is high,
//   so req_stall is the result register being full and stalled.
//   reset: synchronous, clears the message state, the stored bytes, the
//   result valid flag and loads the default limits 20, 40 and 1000.
//   csr writes are taken any cycle and are meant for idle periods.
module framed_serial_command_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fscd_pkg::BYTE_W-1:0]         req_rx_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_command_kind,
   output logic signed [fscd_pkg::VALUE_W-1:0] rsp_decoded_value,
   output logic                                rsp_in_range,
   // configuration port
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [fscd_pkg::CSR_W-1:0]          csr_write_data
);

   // limit registers
   logic [fscd_pkg::FREQ_W-1:0]   freq_min_ff;
   logic [fscd_pkg::FREQ_W-1:0]   freq_max_ff;
   logic [fscd_pkg::THRESH_W-1:0] thresh_max_ff;

   // message state and byte store
   logic                           in_message_ff, in_message_in;
   logic [fscd_pkg::INDEX_W-1:0]   write_index_ff, write_index_in;
   logic [fscd_pkg::BYTE_W-1:0]    store_ff [fscd_pkg::STORE_DEPTH];
   logic                           store_write;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   logic signed [fscd_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                                rsp_range_ff, rsp_range_in;

   logic accept;
   logic is_open;
   logic is_close;
   logic close_hit;
   logic result_hit;

   logic signed [fscd_pkg::VALUE_W-1:0] d1, d2, d3, d4;
   logic signed [fscd_pkg::VALUE_W-1:0] freq_value;
   logic signed [fscd_pkg::VALUE_W-1:0] thresh_value;
   logic                                freq_ok;
   logic                                thresh_ok;
   fscd_pkg::csr_index_type             csr_sel;

   // the result register is the only thing that can hold a request back
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_open   = (req_rx_byte == fscd_pkg::BYTE_OPEN);
   assign is_close  = (req_rx_byte == fscd_pkg::BYTE_CLOSE);
   assign close_hit = accept & is_close & in_message_ff;

   // data bytes advance the position until it saturates
   assign store_write = accept & ~is_open & ~is_close
                        & (write_index_ff < fscd_pkg::INDEX_W'(fscd_pkg::INDEX_LIMIT));

   always_comb begin
      in_message_in  = in_message_ff;
      write_index_in = write_index_ff;
      if (accept && is_open) begin
         in_message_in  = 1'b1;
         write_index_in = '0;
      end else if (close_hit) begin
         in_message_in = 1'b0;
      end else if (store_write) begin
         write_index_in = write_index_ff + fscd_pkg::INDEX_W'(1);
      end
   end

   // digits from the stored command bytes
   assign d1 = fscd_pkg::digit_value(store_ff[1]);
   assign d2 = fscd_pkg::digit_value(store_ff[2]);
   assign d3 = fscd_pkg::digit_value(store_ff[3]);
   assign d4 = fscd_pkg::digit_value(store_ff[4]);

   assign freq_value   = d1 * fscd_pkg::K10 + d2;
   assign thresh_value = d1 * fscd_pkg::K1000 + d2 * fscd_pkg::K100
                         + d3 * fscd_pkg::K10 + d4;

   assign freq_ok = (freq_value >= $signed(fscd_pkg::VALUE_W'(freq_min_ff)))
                    && (freq_value <= $signed(fscd_pkg::VALUE_W'(freq_max_ff)));
   assign thresh_ok = ~thresh_value[fscd_pkg::VALUE_W-1]
                      && (thresh_value <= $signed(fscd_pkg::VALUE_W'(thresh_max_ff)));

   // pick the command; anything else closes without a result
   always_comb begin
      result_hit   = 1'b0;
      rsp_kind_in  = 1'b0;
      rsp_value_in = freq_value;
      rsp_range_in = freq_ok;
      case (store_ff[0])
         fscd_pkg::CMD_FREQ: begin
            result_hit = close_hit;
         end
         fscd_pkg::CMD_THRESH: begin
            result_hit   = close_hit;
            rsp_kind_in  = 1'b1;
            rsp_value_in = thresh_value;
            rsp_range_in = thresh_ok;
         end
         default: begin
            result_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_hit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_sel = fscd_pkg::csr_index_type'(csr_index);

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_min_ff   <= fscd_pkg::FREQ_MIN_RESET;
         freq_max_ff   <= fscd_pkg::FREQ_MAX_RESET;
         thresh_max_ff <= fscd_pkg::THRESH_MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_sel)
            fscd_pkg::CSR_FREQ_MIN:   freq_min_ff   <= csr_write_data[fscd_pkg::FREQ_W-1:0];
            fscd_pkg::CSR_FREQ_MAX:   freq_max_ff   <= csr_write_data[fscd_pkg::FREQ_W-1:0];
            fscd_pkg::CSR_THRESH_MAX: thresh_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // message state and store, store cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff  <= 1'b0;
         write_index_ff <= '0;
         for (int i = 0; i < fscd_pkg::STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         in_message_ff  <= in_message_in;
         write_index_ff <= write_index_in;
         if (store_write
             && write_index_ff < fscd_pkg::INDEX_W'(fscd_pkg::STORE_DEPTH)) begin
            store_ff[write_index_ff[fscd_pkg::STORE_AW-1:0]] <= req_rx_byte;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_hit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
         rsp_range_ff <= rsp_range_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command_kind  = rsp_kind_ff;
   assign rsp_decoded_value = rsp_value_ff;
   assign rsp_in_range      = rsp_range_ff;

endmodule

FILE: hdl/fscd_checker.sv
// port-level checker for the framed serial command decoder, bound to the top level
// depends on fscd_pkg and assert_macros.svh
`include "assert_macros.svh"

module fscd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [fscd_pkg::BYTE_W-1:0]         req_rx_byte,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_command_kind,
   input logic signed [fscd_pkg::VALUE_W-1:0] rsp_decoded_value,
   input logic                                rsp_in_range
);

   logic                           rsp_blocked;
   logic [fscd_pkg::VALUE_W+1:0]   rsp_fields;
   logic                           close_take;
   logic                           thresh_shown_ok;
   logic                           value_negative;

   assign rsp_blocked     = rsp_valid && rsp_stall;
   assign rsp_fields      = {rsp_command_kind, rsp_decoded_value, rsp_in_range};
   assign close_take      = req_valid && !req_stall && (req_rx_byte == fscd_pkg::BYTE_CLOSE);
   assign thresh_shown_ok = rsp_valid && rsp_command_kind && rsp_in_range;
   assign value_negative  = rsp_decoded_value[fscd_pkg::VALUE_W-1];

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, rsp_blocked |=> rsp_valid && $stable(rsp_fields), "held result changed")

   // nothing is shown right after reset
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // a fresh result follows a taken close byte
   `ASSERT_CLK(a_rsp_cause, rsp_valid && !$past(rsp_blocked) |-> $past(close_take), "stray result")

   // an accepted threshold is never negative
   `ASSERT_CLK(a_thresh_sign, thresh_shown_ok |-> !value_negative, "negative threshold in range")

endmodule

bind framed_serial_command_decoder fscd_checker u_fscd_checker (.*);
